/* rtl/rbs_pkg.sv */
// Package for the ray/box slab block: lane types, divider step, quotient saturation.
// No dependencies; imported by all rtl modules.
`default_nettype none
package rbs_pkg;

    localparam int NumLanes  = 6;
    localparam int NumAxes   = 3;
    localparam int QuoBits   = 32;
    localparam int FracBits  = 16;
    localparam int CfgRegs   = 6;
    localparam int CfgIdxW   = 3;

    localparam logic [CfgIdxW-1:0] RegMinX = 3'd0;
    localparam logic [CfgIdxW-1:0] RegMinY = 3'd1;
    localparam logic [CfgIdxW-1:0] RegMinZ = 3'd2;
    localparam logic [CfgIdxW-1:0] RegMaxX = 3'd3;
    localparam logic [CfgIdxW-1:0] RegMaxY = 3'd4;
    localparam logic [CfgIdxW-1:0] RegMaxZ = 3'd5;

    localparam logic signed [31:0] SatHi = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SatLo = 32'sh8000_0000;

    typedef struct packed {
        logic dz;     // direction is zero
        logic ovf;    // magnitude quotient >= 2^32
        logic neg;    // quotient sign
        logic nsign;  // numerator negative
        logic nzero;  // numerator zero
    } rbs_flags_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] dvd;
        logic [31:0] div;
        logic [31:0] q;
        rbs_flags_t  flags;
    } rbs_div_t;

    function automatic rbs_div_t rbs_front_lane(logic signed [31:0] corner,
                                                logic signed [31:0] orig,
                                                logic signed [31:0] dir);
        logic signed [32:0] num;
        logic [31:0]        an;
        logic [31:0]        ad;
        rbs_div_t           r;
        num = 33'(corner) - 33'(orig);
        an  = num[32] ? 32'(-num) : num[31:0];
        ad  = dir[31] ? 32'(-33'(dir)) : dir;
        r.flags.dz    = (dir == '0);
        r.flags.ovf   = ({16'b0, an[31:16]} >= ad);
        r.flags.nsign = num[32];
        r.flags.neg   = num[32] ^ dir[31];
        r.flags.nzero = (num == '0);
        r.rem = {16'b0, an[31:16]};
        r.dvd = {an[15:0], 16'b0};
        r.div = ad;
        r.q   = '0;
        return r;
    endfunction

    function automatic rbs_div_t rbs_div_step(rbs_div_t a);
        logic [32:0] t;
        logic [32:0] d;
        logic        ge;
        rbs_div_t    r;
        t  = {a.rem, a.dvd[31]};
        d  = {1'b0, a.div};
        ge = (t >= d);
        r       = a;
        r.rem   = ge ? 32'(t - d) : t[31:0];
        r.dvd   = {a.dvd[30:0], 1'b0};
        r.q     = {a.q[30:0], ge};
        return r;
    endfunction

    function automatic logic signed [31:0] rbs_saturate(logic [31:0] q, rbs_flags_t f);
        logic signed [31:0] r;
        if (f.dz) begin
            if (f.nzero)
                r = '0;
            else
                r = f.nsign ? SatLo : SatHi;
        end else if (f.ovf) begin
            r = f.neg ? SatLo : SatHi;
        end else if (f.neg) begin
            r = (q > 32'h8000_0000) ? SatLo : 32'(-33'(q));
        end else begin
            r = (q > 32'h7FFF_FFFF) ? SatHi : q;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/rbs_front.sv */
// Front stage: corner-origin differences, magnitudes and divider seeds for six lanes.
// Depends on rbs_pkg.
`default_nettype none
module rbs_front (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic signed [31:0]        corner [rbs_pkg::NumLanes],
    input  wire logic signed [31:0]        orig   [rbs_pkg::NumAxes],
    input  wire logic signed [31:0]        dir    [rbs_pkg::NumAxes],
    output rbs_pkg::rbs_div_t              lane_out [rbs_pkg::NumLanes]
);
    import rbs_pkg::*;

    rbs_div_t lane_reg [NumLanes];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NumLanes; i++)
            begin
                lane_reg[i] <= rbs_front_lane(corner[i], orig[i/2], dir[i/2]);
            end
        end
    end

    assign lane_out = lane_reg;

endmodule
`default_nettype wire

/* rtl/rbs_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, one lane.
// Depends on rbs_pkg.
`default_nettype none
module rbs_divider (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire rbs_pkg::rbs_div_t  lane_in,
    output logic [31:0]             q,
    output rbs_pkg::rbs_flags_t     flags
);
    import rbs_pkg::*;

    rbs_div_t stage_reg [QuoBits];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= rbs_div_step(lane_in);
        end
    end

    for (genvar s = 1; s < QuoBits; s++) begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[s] <= rbs_div_step(stage_reg[s-1]);
            end
        end
    end

    assign q     = stage_reg[QuoBits-1].q;
    assign flags = stage_reg[QuoBits-1].flags;

endmodule
`default_nettype wire

/* rtl/rbs_merge.sv */
// Saturation, per-axis near/far, then max of nears and min of fars; two stages.
// Depends on rbs_pkg.
`default_nettype none
module rbs_merge (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [31:0]          q     [rbs_pkg::NumLanes],
    input  wire rbs_pkg::rbs_flags_t  flags [rbs_pkg::NumLanes],
    output logic signed [31:0]        t_enter,
    output logic signed [31:0]        t_exit
);
    import rbs_pkg::*;

    logic signed [31:0] near_reg [NumAxes];
    logic signed [31:0] far_reg  [NumAxes];
    logic signed [31:0] enter_reg;
    logic signed [31:0] exit_reg;
    logic signed [31:0] t0 [NumAxes];
    logic signed [31:0] t1 [NumAxes];
    logic signed [31:0] enter_next;
    logic signed [31:0] exit_next;

    always_comb
    begin
        for (int a = 0; a < NumAxes; a++)
        begin
            t0[a] = rbs_saturate(q[2*a], flags[2*a]);
            t1[a] = rbs_saturate(q[2*a+1], flags[2*a+1]);
        end
        enter_next = near_reg[0];
        exit_next  = far_reg[0];
        for (int a = 1; a < NumAxes; a++)
        begin
            if (near_reg[a] > enter_next)
                enter_next = near_reg[a];
            if (far_reg[a] < exit_next)
                exit_next = far_reg[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NumAxes; a++)
            begin
                near_reg[a] <= (t0[a] < t1[a]) ? t0[a] : t1[a];
                far_reg[a]  <= (t0[a] > t1[a]) ? t0[a] : t1[a];
            end
            enter_reg <= enter_next;
            exit_reg  <= exit_next;
        end
    end

    assign t_enter = enter_reg;
    assign t_exit  = exit_reg;

endmodule
`default_nettype wire

/* rtl/ray_box_slab_intervals.sv */
// Ray against axis-aligned box slab test, top level.
// Depends on rbs_pkg, rbs_front, rbs_divider, rbs_merge.
//
// Usage:
//   Box corners are six signed Q16.16 registers written through cfg_we /
//   cfg_index / cfg_data (0..2 min x,y,z; 3..5 max x,y,z). Write only while
//   no ray is in flight.
//   Rays enter on s_axis: tdata holds origin x,y,z then direction x,y,z,
//   32 bits each; tlast marks the last ray of a batch.
//   Results leave on m_axis: tdata holds t_enter then t_exit; tlast copies
//   the ray's batch flag. A hit test reads t_enter <= t_exit.
// Pipeline: 1 front stage, 32 divider stages at one quotient bit each,
//   2 merge stages.
// Throughput: one ray per cycle while the output is not stalled; six divider lanes run side by side.
// Reset: clears all valid bits and the box registers to zero.
// Stall: while the output item is held and m_axis_tready is low the whole
//   pipeline freezes, bubbles included, and s_axis_tready drops.
`default_nettype none
module ray_box_slab_intervals (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z
    input  wire logic [191:0]  s_axis_tdata,
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // t_enter, t_exit
    output logic [63:0]        m_axis_tdata,
    output logic               m_axis_tlast
);
    import rbs_pkg::*;

    localparam int Depth = QuoBits + 3;

    logic signed [31:0] box_reg [CfgRegs];
    logic [Depth-1:0]   valid_reg;
    logic [Depth-1:0]   last_reg;
    logic               en;

    logic signed [31:0] corner [NumLanes];
    logic signed [31:0] orig   [NumAxes];
    logic signed [31:0] dir    [NumAxes];
    rbs_div_t           lane   [NumLanes];
    logic [31:0]        q      [NumLanes];
    rbs_flags_t         flags  [NumLanes];
    logic signed [31:0] t_enter;
    logic signed [31:0] t_exit;

    assign en = !valid_reg[Depth-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CfgRegs; i++)
            begin
                box_reg[i] <= '0;
            end
        end else if (cfg_we)
        begin
            case (cfg_index)
                RegMinX: box_reg[0] <= cfg_data;
                RegMinY: box_reg[1] <= cfg_data;
                RegMinZ: box_reg[2] <= cfg_data;
                RegMaxX: box_reg[3] <= cfg_data;
                RegMaxY: box_reg[4] <= cfg_data;
                RegMaxZ: box_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end else if (en)
        begin
            valid_reg <= {valid_reg[Depth-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= {last_reg[Depth-2:0], s_axis_tlast};
        end
    end

    always_comb
    begin
        for (int a = 0; a < NumAxes; a++)
        begin
            orig[a]         = s_axis_tdata[32*a +: 32];
            dir[a]          = s_axis_tdata[32*(a+3) +: 32];
            corner[2*a]     = box_reg[a];
            corner[2*a + 1] = box_reg[a+3];
        end
    end

    rbs_front u_front (
        .clk      (clk),
        .en       (en),
        .corner   (corner),
        .orig     (orig),
        .dir      (dir),
        .lane_out (lane)
    );

    for (genvar i = 0; i < NumLanes; i++) begin : g_div
        rbs_divider u_div (
            .clk     (clk),
            .en      (en),
            .lane_in (lane[i]),
            .q       (q[i]),
            .flags   (flags[i])
        );
    end

    rbs_merge u_merge (
        .clk     (clk),
        .en      (en),
        .q       (q),
        .flags   (flags),
        .t_enter (t_enter),
        .t_exit  (t_exit)
    );

    assign m_axis_tvalid = valid_reg[Depth-1];
    assign m_axis_tlast  = last_reg[Depth-1];
    assign m_axis_tdata  = {t_exit, t_enter};

endmodule
`default_nettype wire

/* bench/ray_box_slab_intervals_test.sv */
// Testbench for ray_box_slab_intervals: streams rays against several box settings
// and checks t_enter, t_exit and the batch flag against an in-bench slab predictor.
// Depends on rbs_pkg and the ray_box_slab_intervals RTL.
`default_nettype none
module ray_box_slab_intervals_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rbs_pkg::*;

    localparam int Latency = 35;
    localparam int CycleLimit = 400000;

    typedef struct packed {
        logic [31:0] t_exit;
        logic [31:0] t_enter;
        logic        batch_end;
    } slab_result_t;

    typedef struct {
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        logic               batch_end;
        logic               has_exp;
        logic signed [31:0] exp_enter;
        logic signed [31:0] exp_exit;
    } ray_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic m_axis_tlast;

    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    slab_result_t pending_hits [$];
    int err_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    ray_box_slab_intervals dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic signed [31:0] slab_quotient(logic signed [31:0] corner,
                                                         logic signed [31:0] orig,
                                                         logic signed [31:0] dir);
        longint num;
        longint den;
        longint an;
        longint ad;
        longint q;
        num = longint'(corner) - longint'(orig);
        den = longint'(dir);
        if (den == 0)
            return (num > 0) ? SatHi : (num < 0) ? SatLo : 32'sd0;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (an <<< FracBits) / ad;
        if ((num < 0) != (den < 0))
            return (q > 64'sh8000_0000) ? SatLo : 32'(-q);
        return (q > 64'sh7FFF_FFFF) ? SatHi : 32'(q);
    endfunction

    function automatic slab_result_t slab_interval(ray_row_t r);
        slab_result_t res;
        logic signed [31:0] t0;
        logic signed [31:0] t1;
        logic signed [31:0] nr;
        logic signed [31:0] fr;
        logic signed [31:0] enter;
        logic signed [31:0] leave;
        enter = '0;
        leave = '0;
        for (int a = 0; a < 3; a++)
        begin
            t0 = slab_quotient(box_lo[a], r.org[a], r.dir[a]);
            t1 = slab_quotient(box_hi[a], r.org[a], r.dir[a]);
            nr = (t0 < t1) ? t0 : t1;
            fr = (t0 > t1) ? t0 : t1;
            if (a == 0 || nr > enter)
                enter = nr;
            if (a == 0 || fr < leave)
                leave = fr;
        end
        res.t_enter = enter;
        res.t_exit = leave;
        res.batch_end = r.batch_end;
        return res;
    endfunction

    task automatic write_box(logic [2:0] idx, logic signed [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx < RegMaxX)
            box_lo[idx[1:0]] = value;
        else
            box_hi[2'(idx - RegMaxX)] = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (Latency + 5) @(negedge clk);
    endtask

    // Drives one ray; called at a falling edge, returns at a falling edge after accept.
    task automatic send_ray(ray_row_t r);
        slab_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r.dir[2], r.dir[1], r.dir[0], r.org[2], r.org[1], r.org[0]};
        s_axis_tlast <= r.batch_end;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = slab_interval(r);
        if (r.has_exp && res.t_enter != r.exp_enter)
        begin
            $error("table t_enter expected %h actual %h", r.exp_enter, res.t_enter);
            err_count++;
        end
        if (r.has_exp && res.t_exit != r.exp_exit)
        begin
            $error("table t_exit expected %h actual %h", r.exp_exit, res.t_exit);
            err_count++;
        end
        pending_hits.push_back(res);
        @(negedge clk);
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        slab_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("result item with nothing expected");
                err_count++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (m_axis_tdata[31:0] !== want.t_enter)
                begin
                    $error("t_enter expected %h actual %h", want.t_enter, m_axis_tdata[31:0]);
                    err_count++;
                end
                if (m_axis_tdata[63:32] !== want.t_exit)
                begin
                    $error("t_exit expected %h actual %h", want.t_exit, m_axis_tdata[63:32]);
                    err_count++;
                end
                if (m_axis_tlast !== want.batch_end)
                begin
                    $error("batch_end expected %b actual %b", want.batch_end, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return SatHi;
            2: return SatLo;
            3: return 32'($urandom_range(0, 1)) - 32'sd0;
            default: return $signed(32'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_dir();
        case ($urandom_range(5))
            0: return $urandom;
            1: return '0;
            2: return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
            default: return $signed(32'($urandom_range(0, 32'h0003_FFFF))) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic ray_row_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                        logic last, logic has, int e_in, int e_out);
        ray_row_t r;
        r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
        r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
        r.batch_end = last;
        r.has_exp = has;
        r.exp_enter = e_in;
        r.exp_exit = e_out;
        return r;
    endfunction

    ray_row_t directed [$];
    ray_row_t r;

    initial
    begin
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = '0;
            box_hi[a] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // box all zero after reset: zero numerators with zero direction give zero
        directed.push_back(mk_ray(0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 0, 0));
        directed.push_back(mk_ray(-65536, -65536, -65536, 0, 0, 0, 1'b1, 1'b1,
                                  SatHi, SatHi));
        directed.push_back(mk_ray(65536, 65536, 65536, 0, 0, 0, 1'b0, 1'b1, SatLo, SatLo));
        directed.push_back(mk_ray(-65536, -65536, -65536, 65536, 65536, 65536, 1'b1, 1'b1,
                                  65536, 65536));
        directed.push_back(mk_ray(SatLo, SatLo, SatLo, 1, 1, 1, 1'b0, 1'b1, SatHi, SatHi));
        directed.push_back(mk_ray(SatHi, SatHi, SatHi, 1, 1, 1, 1'b0, 1'b1, SatLo, SatLo));
        directed.push_back(mk_ray(SatLo, SatHi, 0, SatLo, SatHi, -1, 1'b1, 1'b0, 0, 0));
        directed.push_back(mk_ray(SatHi, SatLo, 1, -1, SatLo, SatHi, 1'b0, 1'b0, 0, 0));
        foreach (directed[i])
            send_ray(directed[i]);
        s_axis_tvalid <= 1'b0;
        drain_results();

        // unit box, then random boxes, then extremes, then swapped corners
        write_box(RegMinX, -32'sd65536);
        write_box(RegMinY, -32'sd65536);
        write_box(RegMinZ, -32'sd65536);
        write_box(RegMaxX, 32'sd65536);
        write_box(RegMaxY, 32'sd65536);
        write_box(RegMaxZ, 32'sd65536);
        directed.delete();
        directed.push_back(mk_ray(-131072, 0, 0, 65536, 0, 0, 1'b0, 1'b0, 0, 0));
        directed.push_back(mk_ray(0, 0, 0, 65536, 65536, 65536, 1'b1, 1'b1, -65536, 65536));
        directed.push_back(mk_ray(0, 0, -131072, -65536, 0, 65536, 1'b0, 1'b0, 0, 0));
        directed.push_back(mk_ray(SatHi, SatLo, 0, 3, -7, 0, 1'b1, 1'b0, 0, 0));
        foreach (directed[i])
            send_ray(directed[i]);
        s_axis_tvalid <= 1'b0;
        drain_results();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 49; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 49; end
                3: begin send_idle_pct = 7; recv_stall_pct = 7; end
                4: begin send_idle_pct = 0; recv_stall_pct = 0; end
                default: begin send_idle_pct = 49; recv_stall_pct = 49; end
            endcase
            if (ph == 4)
            begin
                write_box(RegMinX, SatLo); write_box(RegMinY, SatLo);
                write_box(RegMinZ, SatLo); write_box(RegMaxX, SatHi);
                write_box(RegMaxY, SatHi); write_box(RegMaxZ, SatHi);
            end
            else if (ph == 5)
            begin
                write_box(RegMinX, SatHi); write_box(RegMinY, 32'sd65536);
                write_box(RegMinZ, 32'sd0); write_box(RegMaxX, SatLo);
                write_box(RegMaxY, -32'sd65536); write_box(RegMaxZ, 32'sd0);
            end
            else
            begin
                for (int k = 0; k < 6; k++)
                    write_box(3'(k), rand_coord());
            end
            for (int n = 0; n < 250; n++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    r.org[a] = rand_coord();
                    r.dir[a] = rand_dir();
                end
                r.batch_end = 1'($urandom_range(0, 1));
                r.has_exp = 1'b0;
                send_ray(r);
            end
            s_axis_tvalid <= 1'b0;
            drain_results();
        end

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
rtl/rbs_pkg.sv
rtl/rbs_front.sv
rtl/rbs_divider.sv
rtl/rbs_merge.sv
rtl/ray_box_slab_intervals.sv
bench/ray_box_slab_intervals_test.sv
